// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held
`define TCWE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held
`define TCWE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tcwe_pkg.sv =====
package tcwe_pkg;

  // Field widths
  localparam int CP_BITS        = 21;
  localparam int WIDTH_BITS     = 2;
  localparam int BUDGET_BITS    = 16;
  localparam int MARK_BITS      = 8;
  localparam int OUT_CELL_BITS  = 16;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CELL_BITS_DEF  = 16;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_AMB_WIDE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BUDGET   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MARK     = 2'd2;

  // Register reset values
  localparam logic                   AMB_WIDE_RST = 1'b0;
  localparam logic [BUDGET_BITS-1:0] BUDGET_RST   = 16'd80;
  localparam logic [MARK_BITS-1:0]   MARK_RST     = 8'd1;

  // Cell widths
  localparam logic [WIDTH_BITS-1:0] CW_ZERO   = 2'd0;
  localparam logic [WIDTH_BITS-1:0] CW_NARROW = 2'd1;
  localparam logic [WIDTH_BITS-1:0] CW_WIDE   = 2'd2;

  typedef struct packed {
    logic [CP_BITS-1:0] code_point;
    logic               is_final;
  } tcwe_in_t;

  typedef struct packed {
    logic [WIDTH_BITS-1:0]    cell_width;
    logic                     keep_item;
    logic [OUT_CELL_BITS-1:0] running_cells;
    logic                     whole_fits;
    logic                     end_of_string;
  } tcwe_out_t;

endpackage

// ===== sv/tcwe_classify.sv =====
// Terminal width of one code point: parallel range compares, no state.
module tcwe_classify import tcwe_pkg::*; (
  input  logic [CP_BITS-1:0]    code_point,
  input  logic                  amb_wide,
  output logic [WIDTH_BITS-1:0] cell_width
);

  localparam int N_ZERO = 14;
  localparam int N_WIDE = 15;
  localparam int N_AMB  = 8;

  // Combining, format and variation-selector ranges
  localparam logic [N_ZERO-1:0][CP_BITS-1:0] ZERO_LO = '{
    21'h00300, 21'h00483, 21'h00591, 21'h00610, 21'h0064B, 21'h00670, 21'h006D6,
    21'h00E31, 21'h00E47, 21'h0200B, 21'h02060, 21'h0FE00, 21'h0FE20, 21'hE0100};
  localparam logic [N_ZERO-1:0][CP_BITS-1:0] ZERO_HI = '{
    21'h0036F, 21'h00489, 21'h005BD, 21'h0061A, 21'h0065F, 21'h00670, 21'h006DC,
    21'h00E31, 21'h00E4E, 21'h0200F, 21'h02064, 21'h0FE0F, 21'h0FE2F, 21'hE01EF};

  // East Asian wide and fullwidth ranges
  localparam logic [N_WIDE-1:0][CP_BITS-1:0] WIDE_LO = '{
    21'h01100, 21'h02E80, 21'h03041, 21'h03400, 21'h04E00, 21'h0A000, 21'h0AC00,
    21'h0F900, 21'h0FE10, 21'h0FE30, 21'h0FF00, 21'h0FFE0, 21'h1F300, 21'h1F900,
    21'h20000};
  localparam logic [N_WIDE-1:0][CP_BITS-1:0] WIDE_HI = '{
    21'h0115F, 21'h0303E, 21'h033FF, 21'h04DBF, 21'h09FFF, 21'h0A4CF, 21'h0D7A3,
    21'h0FAFF, 21'h0FE19, 21'h0FE6F, 21'h0FF60, 21'h0FFE6, 21'h1F64F, 21'h1F9FF,
    21'h3FFFD};

  // East Asian ambiguous ranges
  localparam logic [N_AMB-1:0][CP_BITS-1:0] AMB_LO = '{
    21'h000A1, 21'h000B0, 21'h000B6, 21'h02010, 21'h02190, 21'h02500, 21'h025A0,
    21'h02E80};
  localparam logic [N_AMB-1:0][CP_BITS-1:0] AMB_HI = '{
    21'h000A1, 21'h000B4, 21'h000BA, 21'h02027, 21'h021FF, 21'h0257F, 21'h025FF,
    21'h02E80};

  localparam logic [CP_BITS-1:0] C0_END = 21'h00020;
  localparam logic [CP_BITS-1:0] C1_LO  = 21'h0007F;
  localparam logic [CP_BITS-1:0] C1_END = 21'h000A0;

  logic ctrl_hit;
  logic zero_hit;
  logic wide_hit;
  logic amb_hit;

  // Range hits
  always_comb begin
    zero_hit = 1'b0;
    wide_hit = 1'b0;
    amb_hit  = 1'b0;
    for (int i = 0; i < N_ZERO; i++) begin
      zero_hit |= (code_point >= ZERO_LO[i]) && (code_point <= ZERO_HI[i]);
    end
    for (int i = 0; i < N_WIDE; i++) begin
      wide_hit |= (code_point >= WIDE_LO[i]) && (code_point <= WIDE_HI[i]);
    end
    for (int i = 0; i < N_AMB; i++) begin
      amb_hit |= (code_point >= AMB_LO[i]) && (code_point <= AMB_HI[i]);
    end
  end

  // C0 and C1 controls
  assign ctrl_hit = (code_point < C0_END) || ((code_point >= C1_LO) && (code_point < C1_END));

  // Priority: zero width, then ambiguous-as-wide or wide, then narrow
  always_comb begin
    if (ctrl_hit || zero_hit) begin
      cell_width = CW_ZERO;
    end else if ((amb_wide && amb_hit) || wide_hit) begin
      cell_width = CW_WIDE;
    end else begin
      cell_width = CW_NARROW;
    end
  end

endmodule

// ===== sv/terminal_cell_width_elider.sv =====
// Channel   Ports                         Word
// input     in_valid / in_ready           in_data  (code_point, is_final)
// result    out_valid / out_ready         out_data (cell_width, keep_item, running_cells,
//                                                   whole_fits, end_of_string)
// config    cfg_we / cfg_index            cfg_wdata (write only, no wait)
//
// One word per cycle sustained while out_ready holds; a result moves from the input register
// into the result register and leaves once the receiver takes it.
// Input register, then width lookup, running-total add and budget compares, then the
// result register; string state updates as a word moves into the result register.
// A stalled result holds the result register; the input register still takes one more word.
// Reset (rst_n, synchronous) empties both stages, clears the string state and loads
// register defaults: ambiguous narrow, budget 80, mark width 1.
`include "assert_macros.svh"

module terminal_cell_width_elider import tcwe_pkg::*; #(
  parameter int CELL_COUNT_BITS = CELL_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  tcwe_in_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output tcwe_out_t                out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int CB       = CELL_COUNT_BITS;
  localparam int CMP_BITS = (CB > BUDGET_BITS) ? CB : BUDGET_BITS;
  localparam logic [CB-1:0] SAT_MAX = {CB{1'b1}};

  // Config registers
  logic                   amb_wide_r;
  logic [BUDGET_BITS-1:0] budget_r;
  logic [MARK_BITS-1:0]   mark_r;

  // Pipeline
  logic      s1_v_r, s1_v_nxt;
  tcwe_in_t  s1_r;
  logic      out_v_r, out_v_nxt;
  tcwe_out_t out_r, out_nxt;
  logic      adv;

  // String state
  logic [CB-1:0]          total_r, total_nxt;
  logic [BUDGET_BITS-1:0] kept_r, kept_nxt;
  logic                   closed_r, closed_nxt;
  logic                   str_clear;

  logic [WIDTH_BITS-1:0]  cw;
  logic [CB:0]            total_sum;
  logic [CB-1:0]          total_new;
  logic [BUDGET_BITS:0]   kept_sum;
  logic [BUDGET_BITS-1:0] limit;
  logic                   prefix_open;
  logic                   item_fits;
  logic                   whole_fits;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amb_wide_r <= AMB_WIDE_RST;
      budget_r   <= BUDGET_RST;
      mark_r     <= MARK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AMB_WIDE: amb_wide_r <= cfg_wdata[0];
        REG_BUDGET:   budget_r   <= cfg_wdata[BUDGET_BITS-1:0];
        REG_MARK:     mark_r     <= cfg_wdata[MARK_BITS-1:0];
        default:      ;
      endcase
    end
  end

  // Handshake
  assign adv       = s1_v_r && (!out_v_r || out_ready);
  assign in_ready  = !s1_v_r || adv;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  assign s1_v_nxt  = (in_valid && in_ready) ? 1'b1 : (adv ? 1'b0 : s1_v_r);
  assign out_v_nxt = adv ? 1'b1 : (out_ready ? 1'b0 : out_v_r);

  // Width lookup
  tcwe_classify u_classify (
    .code_point (s1_r.code_point),
    .amb_wide   (amb_wide_r),
    .cell_width (cw)
  );

  // Saturating running total
  assign total_sum = {1'b0, total_r} + (CB + 1)'(cw);
  assign total_new = total_sum[CB] ? SAT_MAX : total_sum[CB-1:0];

  // Kept prefix against budget minus mark
  assign limit       = budget_r - BUDGET_BITS'(mark_r);
  assign prefix_open = (budget_r != '0) && (BUDGET_BITS'(mark_r) <= budget_r) && !closed_r;
  assign kept_sum    = {1'b0, kept_r} + (BUDGET_BITS + 1)'(cw);
  assign item_fits   = prefix_open && (kept_sum <= {1'b0, limit});

  // Whole-string fit on the last word
  assign whole_fits = s1_r.is_final && (budget_r != '0) && (total_new != SAT_MAX) &&
                      (CMP_BITS'(total_new) <= CMP_BITS'(budget_r));

  // Next state and result
  always_comb begin
    total_nxt  = total_new;
    kept_nxt   = item_fits ? kept_sum[BUDGET_BITS-1:0] : kept_r;
    closed_nxt = closed_r || (prefix_open && !item_fits);
    if (s1_r.is_final) begin
      total_nxt  = '0;
      kept_nxt   = '0;
      closed_nxt = 1'b0;
    end
    out_nxt.cell_width    = cw;
    out_nxt.keep_item     = item_fits;
    out_nxt.running_cells = OUT_CELL_BITS'(total_new);
    out_nxt.whole_fits    = whole_fits;
    out_nxt.end_of_string = s1_r.is_final;
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      total_r  <= '0;
      kept_r   <= '0;
      closed_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (adv) begin
        total_r  <= total_nxt;
        kept_r   <= kept_nxt;
        closed_r <= closed_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  // String state back at its start
  assign str_clear = (total_r == '0) && (kept_r == '0) && !closed_r;

  // Checks
  `TCWE_ASSERT_NOW(a_width_range, out_v_r, out_r.cell_width <= CW_WIDE, "bad cell width")
  `TCWE_ASSERT_NOW(a_fits_on_last, out_v_r && out_r.whole_fits, out_r.end_of_string, "fits early")
  `TCWE_ASSERT_NXT(a_closed_drops, adv && closed_r, !out_r.keep_item, "kept after close")
  `TCWE_ASSERT_NXT(a_clear_on_last, adv && s1_r.is_final, str_clear, "state not cleared")

endmodule

// ===== bench/tb_terminal_cell_width_elider.sv =====
module tb_terminal_cell_width_elider;
  import tcwe_pkg::*;

  localparam int unsigned CELL_SAT   = (1 << CELL_BITS_DEF) - 1;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned PHASE_WORDS = 110;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

  // Code point spans as lo/hi pairs
  localparam int unsigned ZERO_SPANS [28] = '{
    'h0300, 'h036F, 'h0483, 'h0489, 'h0591, 'h05BD, 'h0610, 'h061A,
    'h064B, 'h065F, 'h0670, 'h0670, 'h06D6, 'h06DC, 'h0E31, 'h0E31,
    'h0E47, 'h0E4E, 'h200B, 'h200F, 'h2060, 'h2064, 'hFE00, 'hFE0F,
    'hFE20, 'hFE2F, 'hE0100, 'hE01EF};
  localparam int unsigned WIDE_SPANS [30] = '{
    'h1100, 'h115F, 'h2E80, 'h303E, 'h3041, 'h33FF, 'h3400, 'h4DBF,
    'h4E00, 'h9FFF, 'hA000, 'hA4CF, 'hAC00, 'hD7A3, 'hF900, 'hFAFF,
    'hFE10, 'hFE19, 'hFE30, 'hFE6F, 'hFF00, 'hFF60, 'hFFE0, 'hFFE6,
    'h1F300, 'h1F64F, 'h1F900, 'h1F9FF, 'h20000, 'h3FFFD};
  localparam int unsigned AMB_SPANS [16] = '{
    'h00A1, 'h00A1, 'h00B0, 'h00B4, 'h00B6, 'h00BA, 'h2010, 'h2027,
    'h2190, 'h21FF, 'h2500, 'h257F, 'h25A0, 'h25FF, 'h2E80, 'h2E80};

  typedef enum {RX_OPEN, RX_COIN, RX_BURSTY, RX_PERIODIC} rx_mode_t;

  // Width predictor and result checker
  class cell_width_scoreboard;
    bit          amb_wide;
    int unsigned budget;
    int unsigned mark;
    int unsigned total_cells;
    int unsigned kept_cells;
    bit          prefix_closed;
    tcwe_out_t   cells_due[$];
    int unsigned errors;

    function new();
      amb_wide      = AMB_WIDE_RST;
      budget        = BUDGET_RST;
      mark          = MARK_RST;
      total_cells   = 0;
      kept_cells    = 0;
      prefix_closed = 1'b0;
      errors        = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_AMB_WIDE: amb_wide = data[0];
        REG_BUDGET:   budget   = data;
        REG_MARK:     mark     = data[MARK_BITS-1:0];
        default: ;
      endcase
    endfunction

    function logic [WIDTH_BITS-1:0] cells_of(int unsigned cp);
      if (cp < 'h20 || (cp >= 'h7F && cp < 'hA0)) return CW_ZERO;
      for (int k = 0; k < $size(ZERO_SPANS); k += 2)
        if (cp >= ZERO_SPANS[k] && cp <= ZERO_SPANS[k+1]) return CW_ZERO;
      if (amb_wide)
        for (int k = 0; k < $size(AMB_SPANS); k += 2)
          if (cp >= AMB_SPANS[k] && cp <= AMB_SPANS[k+1]) return CW_WIDE;
      for (int k = 0; k < $size(WIDE_SPANS); k += 2)
        if (cp >= WIDE_SPANS[k] && cp <= WIDE_SPANS[k+1]) return CW_WIDE;
      return CW_NARROW;
    endfunction

    // Accepted input word: advance string state, queue the expected result
    function void note_word(tcwe_in_t w);
      tcwe_out_t   want;
      int unsigned cw;
      cw = cells_of(w.code_point);
      want = '0;
      want.cell_width = WIDTH_BITS'(cw);
      total_cells += cw;
      if (total_cells > CELL_SAT) total_cells = CELL_SAT;
      if (budget != 0 && mark <= budget && !prefix_closed) begin
        if (kept_cells + cw <= budget - mark) begin
          kept_cells += cw;
          want.keep_item = 1'b1;
        end else begin
          prefix_closed = 1'b1;
        end
      end
      want.whole_fits = w.is_final && budget != 0 && total_cells < CELL_SAT &&
                        total_cells <= budget;
      want.running_cells = OUT_CELL_BITS'(total_cells);
      want.end_of_string = w.is_final;
      cells_due.push_back(want);
      if (w.is_final) begin
        total_cells   = 0;
        kept_cells    = 0;
        prefix_closed = 1'b0;
      end
    endfunction

    function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
        $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_word(tcwe_out_t got);
      tcwe_out_t want;
      if (cells_due.size() == 0) begin
        $display("%0t: result word expected none got %h", $time, got);
        errors++;
        return;
      end
      want = cells_due.pop_front();
      compare_field("cell_width", want.cell_width, got.cell_width);
      compare_field("keep_item", want.keep_item, got.keep_item);
      compare_field("running_cells", want.running_cells, got.running_cells);
      compare_field("whole_fits", want.whole_fits, got.whole_fits);
      compare_field("end_of_string", want.end_of_string, got.end_of_string);
    endfunction

    function int unsigned pending();
      return cells_due.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  tcwe_in_t                 in_data = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  tcwe_out_t                out_data;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  cell_width_scoreboard sb = new();
  int unsigned text_q[$];
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned sent_words = 0;

  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned rx_mode_left = 0;
  int unsigned rx_stall_left = 0;
  int unsigned rx_period = 2;
  int unsigned rx_tick = 0;

  terminal_cell_width_elider u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Receiver stall pattern, switching to a random mode after a random run
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(32, 256);
      rx_period    = $urandom_range(2, 7);
    end else begin
      rx_mode_left--;
    end
    rx_tick++;
    case (rx_mode)
      RX_OPEN:     out_ready <= 1'b1;
      RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: out_ready <= (rx_tick % rx_period) != 0;
      default: begin
        if (rx_stall_left != 0) begin
          rx_stall_left--;
          out_ready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          rx_stall_left = $urandom_range(1, 20);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  // Handshake monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_word(in_data);
      if (out_valid && out_ready) sb.check_word(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  // One input word, with the sender's burst and gap pattern in front of it
  task automatic send_word(input tcwe_in_t w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if ($urandom_range(0, 3) != 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 6)) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1'b1;
    in_data  = w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent_words++;
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Sends text_q as one string, final flag on its last code point
  task automatic send_text(input bit midway_drains);
    tcwe_in_t w;
    for (int i = 0; i < text_q.size(); i++) begin
      if (midway_drains && $urandom_range(0, 79) == 0) drain_results();
      w.code_point = CP_BITS'(text_q[i]);
      w.is_final   = (i == text_q.size() - 1);
      send_word(w);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  // Register writes only with the pipe empty; unused bits get random values
  task automatic apply_settings(input bit amb, input int unsigned budget,
                                input int unsigned mark);
    drain_results();
    write_reg(REG_AMB_WIDE, CFG_DATA_BITS'(($urandom() & 'hFFFE) | amb));
    write_reg(REG_BUDGET, CFG_DATA_BITS'(budget));
    write_reg(REG_MARK, CFG_DATA_BITS'(($urandom() & 'hFF00) | (mark & 'hFF)));
    write_reg(REG_UNUSED, CFG_DATA_BITS'($urandom()));
    cfg_we = 1'b0;
  endtask

  // Random code point: half from the spans above, edges included
  function automatic int unsigned random_code_point();
    int unsigned k;
    int unsigned lo;
    int unsigned hi;
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? $urandom_range(0, 'h1F) : $urandom_range('h7F, 'h9F);
      1, 2: begin
        k  = 2 * $urandom_range(0, $size(ZERO_SPANS) / 2 - 1);
        lo = ZERO_SPANS[k];
        hi = ZERO_SPANS[k+1];
      end
      3: begin
        k  = 2 * $urandom_range(0, $size(AMB_SPANS) / 2 - 1);
        lo = AMB_SPANS[k];
        hi = AMB_SPANS[k+1];
      end
      4, 5: begin
        k  = 2 * $urandom_range(0, $size(WIDE_SPANS) / 2 - 1);
        lo = WIDE_SPANS[k];
        hi = WIDE_SPANS[k+1];
      end
      6: return $urandom_range('h20, 'h7E);
      7: return $urandom_range(0, 'h1FFFFF);
      default: return $urandom_range('hA0, 'h2FFFF);
    endcase
    case ($urandom_range(0, 5))
      0: return lo - 1;
      1: return hi + 1;
      2: return lo;
      3: return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  initial begin
    int unsigned len;
    int unsigned phase_start;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: class boundaries, surrogates and out-of-range points at reset settings
    text_q = '{'h00, 'h1F, 'h20, 'h7E, 'h7F, 'h9F, 'hA0, 'hA1, 'h0300, 'h036F,
               'h1100, 'h115F, 'h4E00, 'h9FFF, 'hAC00, 'hD7A3, 'hD800, 'hDFFF,
               'h10FFFF, 'h110000, 'h1FFFFF, 'hE0100, 'hE01EF};
    send_text(1'b0);

    // Ambiguous wide; prefix closes, then a zero-width point still dropped
    apply_settings(1'b1, 3, 1);
    text_q = '{'hA1, 'h1100, 'h0300, 'h41};
    send_text(1'b0);

    // Zero budget with a zero-width string
    apply_settings(1'b0, 0, 1);
    text_q = '{'h0300};
    send_text(1'b0);

    // Random strings over a range of settings
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: apply_settings(1'b1, 0, 0);
        1: apply_settings(1'b0, 3, 4);
        2: apply_settings(1'b1, 10, 1);
        3: apply_settings(1'b0, 65535, 255);
        4: apply_settings(1'b1, 1, 0);
        5: apply_settings(1'($urandom_range(0, 1)), $urandom_range(0, 65535),
                          $urandom_range(0, 255));
        6: apply_settings(1'($urandom_range(0, 1)), $urandom_range(2, 40),
                          $urandom_range(0, 3));
        default: apply_settings(1'b0, 20, 255);
      endcase
      phase_start = sent_words;
      while (sent_words - phase_start < PHASE_WORDS) begin
        case ($urandom_range(0, 19))
          0:         len = $urandom_range(61, 200);
          1, 2, 3,
          4, 5:      len = $urandom_range(13, 60);
          default:   len = $urandom_range(1, 12);
        endcase
        text_q.delete();
        repeat (len) text_q.push_back(random_code_point());
        send_text(1'b1);
        if ($urandom_range(0, 9) == 0) drain_results();
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/tcwe_pkg.sv
sv/tcwe_classify.sv
sv/terminal_cell_width_elider.sv
bench/tb_terminal_cell_width_elider.sv
